[design/wtwm_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the weekly time window matcher.
package wtwm_pkg;

    localparam int unsigned MAX_PAIRS_DEF = 64;
    localparam int unsigned SECS_PER_DAY  = 86400;
    localparam int unsigned EPOCH_WDAY    = 4;
    localparam int unsigned DAYS_PER_WEEK = 7;
    localparam int unsigned SECS_PER_MIN  = 60;

    // Local time after clamping: 40-bit epoch plus up to 2048 minutes of offset.
    localparam int unsigned LT_W  = 41;
    localparam int unsigned SOD_W = 17;
    localparam int unsigned WD_W  = 3;
    localparam int unsigned BND_W = 20;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 12;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MATCH_MODE    = 3'd0,
        CFG_INVERT_RESULT = 3'd1,
        CFG_DAY_MASK      = 3'd2,
        CFG_MINUTES_WEST  = 3'd3,
        CFG_PAIR_COUNT    = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        MODE_HOURS    = 2'd0,
        MODE_WEEKDAYS = 2'd1,
        MODE_DAYHOURS = 2'd2,
        MODE_WEEKLY   = 2'd3
    } t_mode;

    typedef enum logic {
        REQ_QUERY = 1'b0,
        REQ_WRITE = 1'b1
    } t_req;

    typedef struct packed {
        logic              req_type;
        logic [39:0]       unix_seconds;
        logic [6:0]        entry_index;
        logic [BND_W-1:0]  entry_value;
    } t_in_word;

    typedef struct packed {
        logic              matched;
        logic [WD_W-1:0]   weekday;
        logic [SOD_W-1:0]  seconds_of_day;
    } t_out_word;

    // Status handed from the day divider to the sequencer.
    typedef struct packed {
        logic              done;
        logic [WD_W-1:0]   day_mod7;
        logic [SOD_W-1:0]  rem;
    } t_div_out;

endpackage

[design/wtwm_day_div.sv]
`timescale 1ns / 1ps
// Splits local time into whole days modulo seven and seconds of the day on one shared multiplier.
module wtwm_day_div
    import wtwm_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [LT_W-1:0] i_dividend,
    output t_div_out        o_status
);

    // The day is 128 * 675 seconds. The low seven bits pass straight into the
    // seconds of the day, and the rest is divided by 675 in two 17-bit limbs.
    localparam int unsigned DAY_SHIFT = 7;
    localparam int unsigned DAY_ODD   = SECS_PER_DAY >> DAY_SHIFT;
    localparam int unsigned X_W       = LT_W - DAY_SHIFT;
    localparam int unsigned LIMB_W    = X_W / 2;
    localparam int unsigned LIMB_QUO  = (1 << LIMB_W) / DAY_ODD;
    localparam int unsigned LIMB_MOD  = (1 << LIMB_W) % DAY_ODD;

    localparam int unsigned Y_W  = 24;
    localparam int unsigned QY_W = 15;
    localparam int unsigned Q_W  = 25;
    localparam int unsigned Q7_W = 23;
    localparam int unsigned R_W  = 10;
    localparam int unsigned A_W  = 25;
    localparam int unsigned B_W  = 26;
    localparam int unsigned P_W  = A_W + B_W;

    localparam int unsigned    RECIP_DAY_SH = 34;
    localparam int unsigned    RECIP_WK_SH  = 28;
    localparam longint unsigned RECIP_DAY =
        ((64'd1 << RECIP_DAY_SH) + DAY_ODD - 1) / DAY_ODD;
    localparam longint unsigned RECIP_WK =
        ((64'd1 << RECIP_WK_SH) + DAYS_PER_WEEK - 1) / DAYS_PER_WEEK;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SPLIT_Y,
        ST_SPLIT_Q,
        ST_RECIP_DAY,
        ST_BACK_DAY,
        ST_RECIP_WK,
        ST_BACK_WK
    } t_state;

    t_state            r_state;
    logic [LIMB_W-1:0] r_a;
    logic [LIMB_W-1:0] r_b;
    logic [DAY_SHIFT-1:0] r_lo7;
    logic [Y_W-1:0]    r_y;
    logic [Q_W-1:0]    r_qa;
    logic [QY_W-1:0]   r_qy;
    logic [R_W-1:0]    r_r;
    logic [Q_W-1:0]    r_q;
    logic [Q7_W-1:0]   r_q7;
    logic [WD_W-1:0]   r_mod7;
    logic              r_done;

    logic [A_W-1:0]    mul_a;
    logic [B_W-1:0]    mul_b;
    logic [P_W-1:0]    prod;

    // Operand select for the shared multiplier, one product per step.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            ST_SPLIT_Y: begin
                mul_a = A_W'(r_a);
                mul_b = B_W'(LIMB_MOD);
            end
            ST_SPLIT_Q: begin
                mul_a = A_W'(r_a);
                mul_b = B_W'(LIMB_QUO);
            end
            ST_RECIP_DAY: begin
                mul_a = A_W'(r_y);
                mul_b = B_W'(RECIP_DAY);
            end
            ST_BACK_DAY: begin
                mul_a = A_W'(r_qy);
                mul_b = B_W'(DAY_ODD);
            end
            ST_RECIP_WK: begin
                mul_a = r_q;
                mul_b = B_W'(RECIP_WK);
            end
            ST_BACK_WK: begin
                mul_a = A_W'(r_q7);
                mul_b = B_W'(DAYS_PER_WEEK);
            end
            default: begin
            end
        endcase
        prod = P_W'(mul_a) * P_W'(mul_b);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_a     <= '0;
            r_b     <= '0;
            r_lo7   <= '0;
            r_y     <= '0;
            r_qa    <= '0;
            r_qy    <= '0;
            r_r     <= '0;
            r_q     <= '0;
            r_q7    <= '0;
            r_mod7  <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        r_a     <= i_dividend[LT_W-1 -: LIMB_W];
                        r_b     <= i_dividend[DAY_SHIFT +: LIMB_W];
                        r_lo7   <= i_dividend[DAY_SHIFT-1:0];
                        r_state <= ST_SPLIT_Y;
                    end
                end
                // The high limb folds in as 194 * 675 + 122, leaving a 24-bit rest.
                ST_SPLIT_Y: begin
                    r_y     <= prod[Y_W-1:0] + Y_W'(r_b);
                    r_state <= ST_SPLIT_Q;
                end
                ST_SPLIT_Q: begin
                    r_qa    <= prod[Q_W-1:0];
                    r_state <= ST_RECIP_DAY;
                end
                ST_RECIP_DAY: begin
                    r_qy    <= prod[RECIP_DAY_SH +: QY_W];
                    r_state <= ST_BACK_DAY;
                end
                ST_BACK_DAY: begin
                    r_r     <= R_W'(r_y - prod[Y_W-1:0]);
                    r_q     <= r_qa + Q_W'(r_qy);
                    r_state <= ST_RECIP_WK;
                end
                ST_RECIP_WK: begin
                    r_q7    <= prod[RECIP_WK_SH +: Q7_W];
                    r_state <= ST_BACK_WK;
                end
                ST_BACK_WK: begin
                    r_mod7  <= WD_W'(r_q - prod[Q_W-1:0]);
                    r_done  <= 1'b1;
                    r_state <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_status.done     = r_done;
    assign o_status.day_mod7 = r_mod7;
    assign o_status.rem      = {r_r, r_lo7};

endmodule

[design/weekly_time_window_match.sv]
`timescale 1ns / 1ps
// Top level: matches query times against a table of weekly or daily windows.
// A write word returns its all-zero result, registered at the accepting edge; busy stays low.
// A query in weekday mode (or when the day mask already rejects it) skips the pair scan;
// otherwise it also reads table pairs in turn, so its time grows with the pairs read. The day divider
// (six steps on one shared multiplier) and the pair scan (one pair a cycle) make up the query time.
// Reset is synchronous and active low and leaves the boundary table as it is; results are a
// one-cycle strobe that the receiver cannot stall, and the next query waits for busy to fall.
module weekly_time_window_match
    import wtwm_pkg::*;
#(
    parameter int unsigned MAX_PAIRS = MAX_PAIRS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  t_in_word              i_word,
    output logic                  o_valid,
    output t_out_word             o_word,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int unsigned AW = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
    localparam int unsigned NW = $clog2(MAX_PAIRS + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_PREP,
        ST_SCAN
    } t_state;

    // Configuration registers.
    t_mode              r_mode;
    logic               r_invert;
    logic [6:0]         r_day_mask;
    logic signed [11:0] r_minutes_west;
    logic [6:0]         r_pair_count;

    // Sequencer state and working registers.
    t_state             r_state;
    logic               r_valid;
    t_out_word          r_out;
    logic [WD_W-1:0]    r_wday;
    logic [SOD_W-1:0]   r_sod;
    logic [BND_W-1:0]   r_t;
    logic [NW-1:0]      r_n;
    logic [NW-1:0]      r_addr;
    logic               r_rd_vld;

    // Boundary table, split so that a start and its end are read in the same cycle.
    logic [BND_W-1:0]   r_start_mem [MAX_PAIRS];
    logic [BND_W-1:0]   r_end_mem   [MAX_PAIRS];
    logic [BND_W-1:0]   r_rd_start;
    logic [BND_W-1:0]   r_rd_end;

    logic               accept;
    logic               wr_en;
    logic [31:0]        wr_pair;
    logic signed [17:0] mw_ext;
    logic signed [17:0] ofs;
    logic signed [41:0] local_time;
    logic [LT_W-1:0]    lt_clamped;
    logic               div_start;
    t_div_out           div_st;
    logic [WD_W:0]      wday_sum;
    logic [WD_W-1:0]    wday_calc;
    logic               day_hit;
    logic [NW-1:0]      n_clamped;
    logic               scan_issue;
    logic               scan_miss;
    logic               scan_hit;

    assign accept = start && !busy;

    // A write beyond the table is dropped.
    assign wr_pair = 32'(i_word.entry_index >> 1);
    assign wr_en   = accept && (i_word.req_type == REQ_WRITE)
                     && (32'(i_word.entry_index) < 2 * MAX_PAIRS);

    // Local time is UTC minus the west offset, clamped at the epoch.
    always_comb begin
        mw_ext     = 18'(r_minutes_west);
        ofs        = mw_ext * 18'sd60;
        local_time = $signed({2'b00, i_word.unix_seconds}) - 42'(ofs);
        lt_clamped = local_time[41] ? '0 : local_time[LT_W-1:0];
    end

    assign div_start = accept && (i_word.req_type == REQ_QUERY);

    wtwm_day_div u_day_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (lt_clamped),
        .o_status   (div_st)
    );

    // Epoch day zero is a Thursday, so shift the day count by four before wrapping.
    always_comb begin
        wday_sum = (WD_W + 1)'(div_st.day_mod7) + (WD_W + 1)'(EPOCH_WDAY);
        if (32'(wday_sum) >= DAYS_PER_WEEK) begin
            wday_calc = WD_W'(32'(wday_sum) - DAYS_PER_WEEK);
        end else begin
            wday_calc = wday_sum[WD_W-1:0];
        end
    end

    assign day_hit   = r_day_mask[r_wday];
    assign n_clamped = (32'(r_pair_count) > MAX_PAIRS) ? NW'(MAX_PAIRS) : NW'(r_pair_count);

    // The scan issues one pair read a cycle and checks the pair read the cycle before.
    // It stops at the first start above the time or the first window that holds it.
    assign scan_issue = (r_state == ST_SCAN) && (r_addr < r_n);
    assign scan_miss  = r_rd_vld && (r_t < r_rd_start);
    assign scan_hit   = r_rd_vld && !scan_miss && (r_t <= r_rd_end);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            if (i_word.entry_index[0]) begin
                r_end_mem[wr_pair[AW-1:0]] <= i_word.entry_value;
            end else begin
                r_start_mem[wr_pair[AW-1:0]] <= i_word.entry_value;
            end
        end
        if (scan_issue) begin
            r_rd_start <= r_start_mem[r_addr[AW-1:0]];
            r_rd_end   <= r_end_mem[r_addr[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= MODE_HOURS;
            r_invert       <= 1'b0;
            r_day_mask     <= '0;
            r_minutes_west <= '0;
            r_pair_count   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MATCH_MODE:    r_mode         <= t_mode'(i_cfg_data[1:0]);
                CFG_INVERT_RESULT: r_invert       <= i_cfg_data[0];
                CFG_DAY_MASK:      r_day_mask     <= i_cfg_data[6:0];
                CFG_MINUTES_WEST:  r_minutes_west <= $signed(i_cfg_data);
                CFG_PAIR_COUNT:    r_pair_count   <= i_cfg_data[6:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_valid  <= 1'b0;
            r_out    <= '0;
            r_wday   <= '0;
            r_sod    <= '0;
            r_t      <= '0;
            r_n      <= '0;
            r_addr   <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        if (i_word.req_type == REQ_WRITE) begin
                            r_valid <= 1'b1;
                            r_out   <= '0;
                        end else begin
                            r_state <= ST_DIV;
                        end
                    end
                end
                ST_DIV: begin
                    if (div_st.done) begin
                        r_wday  <= wday_calc;
                        r_sod   <= div_st.rem;
                        r_state <= ST_PREP;
                    end
                end
                ST_PREP: begin
                    // Weekly mode scans seconds since Sunday midnight.
                    if (r_mode == MODE_WEEKLY) begin
                        r_t <= BND_W'(r_sod) + BND_W'(32'(r_wday) * SECS_PER_DAY);
                    end else begin
                        r_t <= BND_W'(r_sod);
                    end
                    r_n      <= n_clamped;
                    r_addr   <= '0;
                    r_rd_vld <= 1'b0;
                    if (r_mode == MODE_WEEKDAYS
                        || (r_mode == MODE_DAYHOURS && !day_hit)) begin
                        r_valid <= 1'b1;
                        r_out   <= '{matched: day_hit ^ r_invert, weekday: r_wday,
                                     seconds_of_day: r_sod};
                        r_state <= ST_IDLE;
                    end else begin
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (scan_hit || scan_miss || !scan_issue) begin
                        r_valid <= 1'b1;
                        r_out   <= '{matched: scan_hit ^ r_invert, weekday: r_wday,
                                     seconds_of_day: r_sod};
                        r_state <= ST_IDLE;
                    end else begin
                        r_addr <= r_addr + 1'b1;
                    end
                    r_rd_vld <= scan_issue;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy    = (r_state != ST_IDLE);
    assign o_valid = r_valid;
    assign o_word  = r_out;

endmodule

[verif/tb_weekly_time_window_match.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the weekly time window matcher: directed and random words.
module tb_weekly_time_window_match;
    import wtwm_pkg::*;

    // The clock runs at 250 MHz. Reset is held low at the start of the run and is
    // never asserted again.
    logic                  i_clk;
    logic                  i_rst_n    = 1'b0;
    logic                  start      = 1'b0;
    logic                  busy;
    t_in_word              i_word     = '0;
    logic                  o_valid;
    t_out_word             o_word;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    weekly_time_window_match u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_word     (i_word),
        .o_valid    (o_valid),
        .o_word     (o_word),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // The run normally ends well inside this bound. The slowest legal run is under
    // 1000 words, each at the longest query time plus the longest gap, roughly 0.3 ms.
    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    // Shadow copy of the block's registers and boundary table. The written flags
    // track which slots hold a known value, so that the pair count never lets the
    // block read a slot that was never written.
    t_mode            cur_mode   = MODE_HOURS;
    bit               cur_invert = 1'b0;
    logic [6:0]       cur_mask   = '0;
    int               cur_mw     = 0;
    int               cur_pairs  = 0;
    logic [BND_W-1:0] bnd_table [2*MAX_PAIRS_DEF];
    bit               written   [2*MAX_PAIRS_DEF];

    // Results still owed by the block, oldest first.
    t_out_word pending_matches [$];

    bit idle_on = 1'b1;
    int fail_count    = 0;
    int query_count   = 0;
    int write_count   = 0;
    int match_count   = 0;
    int setting_count = 0;
    int mode_queries [4];

    // Pair scan: walk the pairs in order, give up as soon as a start lies beyond
    // the test time, and succeed on the first pair that holds it (both ends count).
    // A pair count past the table size is cut back to the table size.
    function automatic bit scan_windows(longint unsigned t);
        int n;
        n = (cur_pairs > MAX_PAIRS_DEF) ? MAX_PAIRS_DEF : cur_pairs;
        for (int i = 0; i < n; i++) begin
            if (t < bnd_table[2*i]) return 1'b0;
            if (t <= bnd_table[2*i+1]) return 1'b1;
        end
        return 1'b0;
    endfunction

    // Works out the result word of one accepted input word and applies its effect
    // on the table. A table write returns an all-zero word.
    function automatic t_out_word predict_result(t_in_word w);
        t_out_word       r;
        longint signed   shifted;
        longint unsigned lt, sod, wd;
        bit              hit;
        r = '0;
        if (w.req_type == REQ_WRITE) begin
            if (w.entry_index < 2 * MAX_PAIRS_DEF) begin
                bnd_table[w.entry_index] = w.entry_value;
                written[w.entry_index]   = 1'b1;
            end
            return r;
        end
        // Minutes west move the clock back; anything before the epoch is pinned to
        // second zero of day zero, which is a Thursday.
        shifted = longint'(w.unix_seconds) - 60 * longint'(cur_mw);
        lt  = (shifted < 0) ? 64'd0 : shifted;
        sod = lt % SECS_PER_DAY;
        wd  = (lt / SECS_PER_DAY + EPOCH_WDAY) % DAYS_PER_WEEK;
        case (cur_mode)
            MODE_HOURS:    hit = scan_windows(sod);
            MODE_WEEKDAYS: hit = cur_mask[wd];
            MODE_DAYHOURS: hit = cur_mask[wd] && scan_windows(sod);
            default:       hit = scan_windows(sod + wd * SECS_PER_DAY);
        endcase
        r.matched        = hit ^ cur_invert;
        r.weekday        = WD_W'(wd);
        r.seconds_of_day = SOD_W'(sod);
        return r;
    endfunction

    // Number of leading pairs whose start and end slots both hold known values.
    function automatic int ready_pairs();
        for (int i = 0; i < MAX_PAIRS_DEF; i++) begin
            if (!(written[2*i] && written[2*i+1])) return i;
        end
        return MAX_PAIRS_DEF;
    endfunction

    // Sends one word. The sender first idles for a random number of cycles (when
    // idling is on), then raises start and keeps it up until an edge finds busy low.
    // With no gap start simply stays high from the previous word, so it is never
    // lowered and raised within one time step.
    task automatic send_word(t_in_word w);
        int gap;
        gap = idle_on ? $urandom_range(0, 12) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_word <= w;
        do @(posedge i_clk); while (busy !== 1'b0);
        if (w.req_type == REQ_QUERY) begin
            query_count++;
            mode_queries[int'(cur_mode)]++;
        end else begin
            write_count++;
        end
        pending_matches.push_back(predict_result(w));
    endtask

    // A table write; the time field carries noise the block must ignore.
    task automatic send_write(logic [6:0] idx, logic [BND_W-1:0] value);
        t_in_word w;
        w.req_type     = REQ_WRITE;
        w.unix_seconds = 40'({$urandom, $urandom});
        w.entry_index  = idx;
        w.entry_value  = value;
        send_word(w);
    endtask

    // A time query; the slot fields carry noise the block must ignore.
    task automatic send_query(logic [39:0] secs);
        t_in_word w;
        w.req_type     = REQ_QUERY;
        w.unix_seconds = secs;
        w.entry_index  = 7'($urandom);
        w.entry_value  = BND_W'($urandom);
        send_word(w);
    endtask

    // Drops start and waits until every owed result is in and the block is idle,
    // with a short margin before registers are touched.
    task automatic wait_idle();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_matches.size() != 0 || busy !== 1'b0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    // Writes all five registers back to back while the block is idle and mirrors
    // them in the shadow copy.
    task automatic apply_config(t_mode m, bit inv, logic [6:0] mask,
                                logic signed [11:0] mw, logic [6:0] pc);
        wait_idle();
        write_reg(CFG_MATCH_MODE,    CFG_DATA_W'(m));
        write_reg(CFG_INVERT_RESULT, CFG_DATA_W'(inv));
        write_reg(CFG_DAY_MASK,      CFG_DATA_W'(mask));
        write_reg(CFG_MINUTES_WEST,  mw);
        write_reg(CFG_PAIR_COUNT,    CFG_DATA_W'(pc));
        i_cfg_we   <= 1'b0;
        cur_mode   = m;
        cur_invert = inv;
        cur_mask   = mask;
        cur_mw     = int'(mw);
        cur_pairs  = int'(pc);
        setting_count++;
    endtask

    // Loads k pairs into the front of the table. Normally they are sorted windows
    // spread over the span (a day or a week); scrambled loads use raw 20-bit values
    // in no order, which the scan must handle just the same.
    task automatic load_windows(int k, int span, bit scrambled);
        int seg, s, e;
        seg = span / k;
        for (int i = 0; i < k; i++) begin
            if (scrambled) begin
                s = $urandom_range(0, 20'hFFFFF);
                e = $urandom_range(0, 20'hFFFFF);
            end else begin
                s = i * seg + $urandom_range(0, seg / 2);
                e = s + $urandom_range(0, seg / 2 - 1);
            end
            send_write(7'(2 * i), BND_W'(s));
            send_write(7'(2 * i + 1), BND_W'(e));
        end
    endtask

    // Chooses a query time. Half of the queries aim at a stored boundary, one second
    // either side of it or right on it, in the current mode's time base; the rest are
    // fully random 40-bit times, times near the epoch, and ordinary dates.
    function automatic logic [39:0] pick_query_time();
        longint signed lt, target;
        int n, sel, slot;
        n   = (cur_pairs > MAX_PAIRS_DEF) ? MAX_PAIRS_DEF : cur_pairs;
        sel = $urandom_range(0, 9);
        if (sel < 5 && n > 0 && cur_mode != MODE_WEEKDAYS) begin
            slot   = $urandom_range(0, 2 * n - 1);
            target = longint'(bnd_table[slot]) + int'($urandom_range(0, 2)) - 1;
            if (target < 0) target = 0;
            if (cur_mode == MODE_WEEKLY) begin
                // Epoch day 3 is a Sunday, so weeks start on days 3 + 7w.
                lt = (3 + 7 * longint'($urandom_range(0, 1 << 20))) * SECS_PER_DAY + target;
            end else begin
                if (target >= SECS_PER_DAY) target = $urandom_range(0, SECS_PER_DAY - 1);
                lt = longint'($urandom_range(2, 7 << 20)) * SECS_PER_DAY + target;
            end
            return 40'(lt + 60 * longint'(cur_mw));
        end else if (sel < 7) begin
            return 40'({$urandom, $urandom});
        end else if (sel == 7) begin
            return 40'($urandom_range(0, 200000));
        end
        return 40'({$urandom_range(0, 1), $urandom});
    endfunction

    // Result checker: every strobed word is compared, field by field, with the
    // oldest owed result.
    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && o_valid === 1'b1) begin
            if (pending_matches.size() == 0) begin
                $error("result word with none owed: matched=%0d weekday=%0d seconds_of_day=%0d",
                       o_word.matched, o_word.weekday, o_word.seconds_of_day);
                fail_count++;
            end else begin
                want = pending_matches.pop_front();
                if (o_word.matched !== want.matched) begin
                    $error("matched: expected %0d, got %0d", want.matched, o_word.matched);
                    fail_count++;
                end
                if (o_word.weekday !== want.weekday) begin
                    $error("weekday: expected %0d, got %0d", want.weekday, o_word.weekday);
                    fail_count++;
                end
                if (o_word.seconds_of_day !== want.seconds_of_day) begin
                    $error("seconds_of_day: expected %0d, got %0d",
                           want.seconds_of_day, o_word.seconds_of_day);
                    fail_count++;
                end
                if (o_word.matched === 1'b1) match_count++;
            end
        end
    end

    // Table writes return zero words. The table gets three day windows, and the
    // extreme slots and values are written too.
    task automatic test_write_words();
        send_write(7'd0, 20'd3600);
        send_write(7'd1, 20'd7200);
        send_write(7'd2, 20'd36000);
        send_write(7'd3, 20'd43200);
        send_write(7'd4, 20'd80000);
        send_write(7'd5, 20'd86399);
        send_write(7'd126, 20'd0);
        send_write(7'd127, 20'hFFFFF);
    endtask

    // Hours mode: before the first window (early stop), on both edges of a window,
    // one second past it, and the very last second of the day.
    task automatic test_hour_windows();
        apply_config(MODE_HOURS, 1'b0, 7'h00, 12'sh000, 7'd3);
        send_query(40'd3599);
        send_query(40'd3600);
        send_query(40'd7200);
        send_query(40'd7201);
        send_query(40'd86399);
    endtask

    // Weekday mask alone (Thursday only), then days-and-hours with inversion on a
    // Sunday inside and outside a window.
    task automatic test_day_mask();
        apply_config(MODE_WEEKDAYS, 1'b0, 7'h10, 12'sh000, 7'd3);
        send_query(40'd0);
        send_query(40'd172800);
        apply_config(MODE_DAYHOURS, 1'b1, 7'h7F, 12'sh000, 7'd3);
        send_query(40'd262800);
        send_query(40'd272800);
    endtask

    // Weekly mode: a Sunday falls in the day-sized windows, a Thursday lies past them.
    task automatic test_weekly_ranges();
        apply_config(MODE_WEEKLY, 1'b0, 7'h00, 12'sh000, 7'd3);
        send_query(40'd262800);
        send_query(40'd3600);
    endtask

    // Offset extremes: a time pushed before the epoch is pinned at zero, and the
    // largest time pushed further forward still splits correctly.
    task automatic test_time_limits();
        apply_config(MODE_HOURS, 1'b0, 7'h00, 12'sh7FF, 7'd3);
        send_query(40'd5);
        apply_config(MODE_HOURS, 1'b0, 7'h00, 12'sh800, 7'd3);
        send_query(40'hFF_FFFF_FFFF);
        send_query(40'd0);
    endtask

    // Random phases: an occasional table reload (the first one fills the whole
    // table, so pair counts past the table size can be used), a fresh register
    // setting, then a burst of queries sprinkled with stray table writes.
    task automatic test_random_traffic();
        int                 done, k, nq, rp;
        t_mode              m;
        logic [6:0]         mask, pc;
        logic signed [11:0] mw;
        done = 0;
        for (int phase = 0; done < 800; phase++) begin
            idle_on = ($urandom_range(0, 2) != 0);
            m = t_mode'($urandom_range(0, 3));
            if (phase == 0 || $urandom_range(0, 2) == 0) begin
                k = (phase == 0 || $urandom_range(0, 4) == 0) ? MAX_PAIRS_DEF
                                                              : $urandom_range(1, 12);
                load_windows(k, (m == MODE_WEEKLY) ? 7 * SECS_PER_DAY : SECS_PER_DAY,
                             phase != 0 && $urandom_range(0, 5) == 0);
                done += 2 * k;
            end
            case ($urandom_range(0, 3))
                0:       mask = 7'h00;
                1:       mask = 7'h7F;
                default: mask = 7'($urandom);
            endcase
            case ($urandom_range(0, 5))
                0:       mw = 12'sh7FF;
                1:       mw = 12'sh800;
                2:       mw = $urandom_range(0, 1) ? 12'sd1440 : -12'sd1440;
                3:       mw = 12'sh000;
                default: mw = 12'(int'($urandom_range(0, 2880)) - 1440);
            endcase
            // Never let the scan reach a slot that holds no known value.
            rp = ready_pairs();
            if (phase == 0) begin
                pc = 7'd127;
            end else if (rp == MAX_PAIRS_DEF) begin
                case ($urandom_range(0, 3))
                    0:       pc = 7'd127;
                    1:       pc = 7'd64;
                    2:       pc = 7'($urandom_range(65, 127));
                    default: pc = 7'($urandom_range(0, 64));
                endcase
            end else begin
                pc = 7'($urandom_range(0, rp));
            end
            apply_config(m, 1'($urandom_range(0, 1)), mask, mw, pc);
            nq = $urandom_range(15, 40);
            for (int q = 0; q < nq; q++) begin
                if ($urandom_range(0, 11) == 0) send_write(7'($urandom), BND_W'($urandom));
                else send_query(pick_query_time());
            end
            done += nq;
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_write_words();
        test_hour_windows();
        test_day_mask();
        test_weekly_ranges();
        test_time_limits();
        test_random_traffic();

        // Drain, then allow one more full query time for any stray result word.
        wait_idle();
        repeat (100) @(posedge i_clk);

        $display("Ran %0d queries and %0d table writes over %0d register settings; %0d matched.",
                 query_count, write_count, setting_count, match_count);
        $display("Queries by mode: hours %0d, weekdays %0d, days and hours %0d, weekly %0d.",
                 mode_queries[0], mode_queries[1], mode_queries[2], mode_queries[3]);
        if (fail_count == 0 && pending_matches.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

[weekly_time_window_match.f]
design/wtwm_pkg.sv
design/wtwm_day_div.sv
design/weekly_time_window_match.sv
verif/tb_weekly_time_window_match.sv
